// ===== design/ata_pkg.sv =====
// Shared types, widths and constants for the accelerometer tilt angle pipeline.
package ata_pkg;

    localparam int AXIS_W    = 16;
    localparam int SUM_W     = 32;
    localparam int SQ_STEPS  = 24;
    localparam int ROOT_W    = 24;
    localparam int REM_W     = 25;
    localparam int CW        = 28;
    localparam int ATAN_W    = 26;
    localparam int TABLE_LEN = 24;
    localparam int TILT_W    = 16;

    localparam logic signed [ATAN_W-1:0] ACC_INIT_NEG_Z = ATAN_W'(5898240);
    localparam logic signed [ATAN_W-1:0] ROUND_HALF     = ATAN_W'(128);
    localparam logic signed [ATAN_W-1:0] TILT_MAX_Q8    = ATAN_W'(46080);

    localparam logic signed [ATAN_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
        ATAN_W'(2949120), ATAN_W'(1740967), ATAN_W'(919879), ATAN_W'(466945),
        ATAN_W'(234379),  ATAN_W'(117304),  ATAN_W'(58666),  ATAN_W'(29335),
        ATAN_W'(14668),   ATAN_W'(7334),    ATAN_W'(3667),   ATAN_W'(1833),
        ATAN_W'(917),     ATAN_W'(458),     ATAN_W'(229),    ATAN_W'(115),
        ATAN_W'(57),      ATAN_W'(29),      ATAN_W'(14),     ATAN_W'(7),
        ATAN_W'(4),       ATAN_W'(2),       ATAN_W'(1),      ATAN_W'(0)
    };

    typedef struct packed {
        logic                     valid;
        logic                     zero;
        logic signed [AXIS_W-1:0] z;
    } t_tag;

endpackage

// ===== design/ata_isqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
module ata_isqrt
    import ata_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_tag              i_tag,
    input  logic [SUM_W-1:0]  i_sum,
    output t_tag              o_tag,
    output logic [ROOT_W-1:0] o_root
);

    t_tag              w_tag [0:SQ_STEPS];
    logic [REM_W-1:0]  w_rem [0:SQ_STEPS];
    logic [ROOT_W-1:0] w_q   [0:SQ_STEPS];
    logic [SUM_W-1:0]  w_rad [0:SQ_STEPS];

    assign w_tag[0] = i_tag;
    assign w_rem[0] = '0;
    assign w_q[0]   = '0;
    assign w_rad[0] = i_sum;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        t_tag              r_tag;
        logic [REM_W-1:0]  r_rem;
        logic [ROOT_W-1:0] r_q;
        logic [SUM_W-1:0]  r_rad;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              ge;
        logic [REM_W+1:0]  n_rem;

        always_comb begin
            rem_sh = {w_rem[k], w_rad[k][SUM_W-1 -: 2]};
            trial  = {1'b0, w_q[k], 2'b01};
            ge     = (rem_sh >= trial);
            n_rem  = ge ? (rem_sh - trial) : rem_sh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag <= '0;
            end else if (i_en) begin
                r_tag <= w_tag[k];
            end
            if (i_en) begin
                r_rem <= n_rem[REM_W-1:0];
                r_q   <= {w_q[k][ROOT_W-2:0], ge};
                r_rad <= {w_rad[k][SUM_W-3:0], 2'b00};
            end
        end

        assign w_tag[k+1] = r_tag;
        assign w_rem[k+1] = r_rem;
        assign w_q[k+1]   = r_q;
        assign w_rad[k+1] = r_rad;
    end

    assign o_tag  = w_tag[SQ_STEPS];
    assign o_root = w_q[SQ_STEPS];

endmodule

// ===== design/ata_cordic.sv =====
// Vectoring CORDIC pipeline giving the angle of (z, h) in degrees with 16 fraction bits.
module ata_cordic
    import ata_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_tag                     i_tag,
    input  logic [ROOT_W-1:0]        i_root,
    output t_tag                     o_tag,
    output logic signed [ATAN_W-1:0] o_acc
);

    localparam int NST = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    t_tag                     w_tag [0:NST];
    logic signed [CW-1:0]     w_cx  [0:NST];
    logic signed [CW-1:0]     w_cy  [0:NST];
    logic signed [ATAN_W-1:0] w_acc [0:NST];

    t_tag                     r_tag0;
    logic signed [CW-1:0]     r_cx0;
    logic signed [CW-1:0]     r_cy0;
    logic signed [ATAN_W-1:0] r_acc0;
    logic signed [CW-1:0]     z_sc;
    logic signed [CW-1:0]     h_ext;

    assign z_sc  = {{(CW-AXIS_W-8){i_tag.z[AXIS_W-1]}}, i_tag.z, 8'h00};
    assign h_ext = {{(CW-ROOT_W){1'b0}}, i_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0 <= '0;
        end else if (i_en) begin
            r_tag0 <= i_tag;
        end
        if (i_en) begin
            if (!i_tag.z[AXIS_W-1]) begin
                r_cx0  <= z_sc;
                r_cy0  <= h_ext;
                r_acc0 <= '0;
            end else begin
                r_cx0  <= h_ext;
                r_cy0  <= -z_sc;
                r_acc0 <= ACC_INIT_NEG_Z;
            end
        end
    end

    assign w_tag[0] = r_tag0;
    assign w_cx[0]  = r_cx0;
    assign w_cy[0]  = r_cy0;
    assign w_acc[0] = r_acc0;

    for (genvar i = 0; i < NST; i++) begin : g_rot
        t_tag                     r_tag;
        logic signed [CW-1:0]     r_cx;
        logic signed [CW-1:0]     r_cy;
        logic signed [ATAN_W-1:0] r_acc;
        logic signed [CW-1:0]     dx;
        logic signed [CW-1:0]     dy;

        assign dx = w_cy[i] >>> i;
        assign dy = w_cx[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag <= '0;
            end else if (i_en) begin
                r_tag <= w_tag[i];
            end
            if (i_en) begin
                if (!w_cy[i][CW-1]) begin
                    r_cx  <= w_cx[i] + dx;
                    r_cy  <= w_cy[i] - dy;
                    r_acc <= w_acc[i] + ATAN_DEG_Q16[i];
                end else begin
                    r_cx  <= w_cx[i] - dx;
                    r_cy  <= w_cy[i] + dy;
                    r_acc <= w_acc[i] - ATAN_DEG_Q16[i];
                end
            end
        end

        assign w_tag[i+1] = r_tag;
        assign w_cx[i+1]  = r_cx;
        assign w_cy[i+1]  = r_cy;
        assign w_acc[i+1] = r_acc;
    end

    assign o_tag = w_tag[NST];
    assign o_acc = w_acc[NST];

endmodule

// ===== design/accel_tilt_angle.sv =====
// Top level of the accelerometer tilt angle pipeline with stream ports.
// Throughput: one word per cycle while the output buffer has room; squaring, 24
// square-root stages and one stage per CORDIC rotation are all fully pipelined.
// A two-entry output buffer catches the word in flight when the sink stalls; the
// pipeline then halts while the second entry is full.
// Reset clears all valid bits; no other state is kept between words.
module accel_tilt_angle
    import ata_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // accel_x, accel_y, accel_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // tilt_degrees
    output logic [0:0]  o_m_axis_tuser    // zero_vector
);

    logic                     en;
    logic signed [AXIS_W-1:0] in_x;
    logic signed [AXIS_W-1:0] in_y;
    logic signed [AXIS_W-1:0] in_z;
    logic signed [2*AXIS_W-1:0] sq_x;
    logic signed [2*AXIS_W-1:0] sq_y;

    t_tag                     r_tag_sq;
    logic [SUM_W-2:0]         r_sq_x;
    logic [SUM_W-2:0]         r_sq_y;
    t_tag                     r_tag_sum;
    logic [SUM_W-1:0]         r_sum;

    t_tag                     sqrt_tag;
    logic [ROOT_W-1:0]        sqrt_root;
    t_tag                     cor_tag;
    logic signed [ATAN_W-1:0] cor_acc;

    logic signed [ATAN_W-1:0] acc_rnd;
    logic signed [ATAN_W-1:0] q8;
    logic [TILT_W-1:0]        tilt;

    logic                     r_q_valid;
    logic [TILT_W-1:0]        r_q_tilt;
    logic                     r_q_zero;
    logic                     r_skid_valid;
    logic [TILT_W-1:0]        r_skid_tilt;
    logic                     r_skid_zero;

    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;

    assign in_x = i_s_axis_tdata[15:0];
    assign in_y = i_s_axis_tdata[31:16];
    assign in_z = i_s_axis_tdata[47:32];
    assign sq_x = in_x * in_x;
    assign sq_y = in_y * in_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_sq  <= '0;
            r_tag_sum <= '0;
        end else if (en) begin
            r_tag_sq.valid <= i_s_axis_tvalid;
            r_tag_sq.zero  <= (in_x == '0) && (in_y == '0) && (in_z == '0);
            r_tag_sq.z     <= in_z;
            r_tag_sum      <= r_tag_sq;
        end
        if (en) begin
            r_sq_x <= sq_x[SUM_W-2:0];
            r_sq_y <= sq_y[SUM_W-2:0];
            r_sum  <= {1'b0, r_sq_x} + {1'b0, r_sq_y};
        end
    end

    ata_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (r_tag_sum),
        .i_sum   (r_sum),
        .o_tag   (sqrt_tag),
        .o_root  (sqrt_root)
    );

    ata_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (sqrt_tag),
        .i_root  (sqrt_root),
        .o_tag   (cor_tag),
        .o_acc   (cor_acc)
    );

    always_comb begin
        acc_rnd = cor_acc + ROUND_HALF;
        q8      = acc_rnd >>> 8;
        if (cor_tag.zero || q8[ATAN_W-1]) begin
            tilt = '0;
        end else if (q8 > TILT_MAX_Q8) begin
            tilt = TILT_MAX_Q8[TILT_W-1:0];
        end else begin
            tilt = q8[TILT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (i_m_axis_tready) begin
                    r_skid_valid <= 1'b0;
                end
            end else begin
                r_q_valid <= cor_tag.valid;
                if (r_q_valid && !i_m_axis_tready) begin
                    r_skid_valid <= 1'b1;
                end
            end
        end
        if (en) begin
            r_q_tilt    <= tilt;
            r_q_zero    <= cor_tag.zero;
            r_skid_tilt <= r_q_tilt;
            r_skid_zero <= r_q_zero;
        end
    end

    assign o_m_axis_tvalid   = r_skid_valid || r_q_valid;
    assign o_m_axis_tdata    = r_skid_valid ? r_skid_tilt : r_q_tilt;
    assign o_m_axis_tuser[0] = r_skid_valid ? r_skid_zero : r_q_zero;

endmodule
